// ===== hw/rtl/counting_sort_engine_top_assert.svh =====
// Assertion macros shared by the counting sort checker
`ifndef COUNTING_SORT_ENGINE_TOP_ASSERT_SVH
`define COUNTING_SORT_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define CSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("counting sort checker: property failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define CSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("counting sort checker: property failed");

`endif

// ===== hw/rtl/cse_pkg.sv =====
// Package: types, codes and defaults of the counting sort engine
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

    // Defaults for the top-level parameters
    localparam int KEY_BITS_DEF  = 10;
    localparam int MAX_ITEMS_DEF = 1024;

    // Fixed field widths
    localparam int KEY_W  = 10;
    localparam int DATA_W = 16;

    // Request kind carried in the input tuser
    typedef enum logic {
        FN_LOAD = 1'b0,
        FN_READ = 1'b1
    } t_func;

    // Result status carried in the output tuser
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // One result between controller and output stage
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
        t_status          status;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/counting_sort_engine_top.sv =====
// Load: accept (bin read), then count read-modify-write; full load or empty read finish at accept.
// Read: from the scan position past empty bins, one bin a cycle, to the first occupied bin.
// A finished result is written into the output register if the slot is free, else held first.
// After reset a clearing pass writes every bin, 2**KEY_BITS bins (1024 by default),
// with s_axis tready low; counts, scan position and output valid reset to zero.
`timescale 1ns / 1ps
`default_nettype none

module counting_sort_engine_top #(
    parameter int KEY_BITS  = cse_pkg::KEY_BITS_DEF,
    parameter int MAX_ITEMS = cse_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request stream
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [cse_pkg::DATA_W-1:0]  i_s_axis_tdata,  // [9:0] key_in
    input  wire logic                        i_s_axis_tuser,  // [0] func
    // result stream
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic [cse_pkg::DATA_W-1:0]       o_m_axis_tdata,  // [9:0] key_out
    output logic                             o_m_axis_tlast,
    output logic [1:0]                       o_m_axis_tuser   // [1:0] status
);

    import cse_pkg::*;

    localparam int NUM_BINS = 1 << KEY_BITS;
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1);

    logic                w_rd_en, w_wr_en;
    logic [KEY_BITS-1:0] w_rd_addr, w_wr_addr;
    logic [CNT_W-1:0]    w_rd_data, w_wr_data;
    logic                w_slot_free, w_res_valid;
    t_result             w_res, w_out;

    // Histogram of per-key counts
    cse_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Controller
    cse_ctrl #(
        .KEY_BITS  (KEY_BITS),
        .MAX_ITEMS (MAX_ITEMS),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_func   (t_func'(i_s_axis_tuser)),
        .i_in_key    (i_s_axis_tdata[KEY_W-1:0]),
        .i_slot_free (w_slot_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    // Output register
    cse_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_slot_free (w_slot_free),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (w_out)
    );

    assign o_m_axis_tdata = {(DATA_W - KEY_W)'(0), w_out.key};
    assign o_m_axis_tlast = w_out.last;
    assign o_m_axis_tuser = w_out.status;

endmodule

`default_nettype wire

// ===== hw/rtl/cse_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module cse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data; data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/cse_ctrl.sv =====
// Controller: clearing pass, histogram read-modify-write and bin scan
`timescale 1ns / 1ps
`default_nettype none

module cse_ctrl #(
    parameter int KEY_BITS  = cse_pkg::KEY_BITS_DEF,
    parameter int MAX_ITEMS = cse_pkg::MAX_ITEMS_DEF,
    parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // request side
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire cse_pkg::t_func             i_in_func,
    input  wire logic [cse_pkg::KEY_W-1:0]  i_in_key,
    // result side
    input  wire logic                       i_slot_free,
    output logic                            o_res_valid,
    output cse_pkg::t_result                o_res,
    // histogram memory
    output logic                            o_rd_en,
    output logic [KEY_BITS-1:0]             o_rd_addr,
    input  wire logic [CNT_W-1:0]           i_rd_data,
    output logic                            o_wr_en,
    output logic [KEY_BITS-1:0]             o_wr_addr,
    output logic [CNT_W-1:0]                o_wr_data
);

    import cse_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOAD  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_HOLD  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_held, n_held;
    logic [KEY_BITS-1:0] r_scan, n_scan;
    logic [KEY_BITS-1:0] r_pos, n_pos;
    logic [KEY_BITS-1:0] r_clr, n_clr;
    t_result             r_res, n_res;

    logic                w_accept;
    logic                w_fin;
    t_result             w_res;
    logic [KEY_BITS-1:0] w_key;
    logic [KEY_W+KEY_BITS-1:0] w_key_ext;
    logic [KEY_W+KEY_BITS-1:0] w_pos_ext;

    // Key resized to the bin index width, and bin index back to the key field
    assign w_key_ext = {KEY_BITS'(0), i_in_key};
    assign w_key     = w_key_ext[KEY_BITS-1:0];
    assign w_pos_ext = {KEY_W'(0), r_pos};

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next-state and memory access logic
    always_comb begin
        n_state   = r_state;
        n_held    = r_held;
        n_scan    = r_scan;
        n_pos     = r_pos;
        n_clr     = r_clr;
        o_rd_en   = 1'b0;
        o_rd_addr = r_pos;
        o_wr_en   = 1'b0;
        o_wr_addr = r_pos;
        o_wr_data = i_rd_data;
        w_fin     = 1'b0;
        w_res     = '{key: '0, last: 1'b0, status: STAT_OK};

        unique case (r_state)
            S_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_clr;
                o_wr_data = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == {KEY_BITS{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_func == FN_LOAD) begin
                        if (r_held >= CNT_W'(MAX_ITEMS)) begin
                            w_fin        = 1'b1;
                            w_res.status = STAT_FULL;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = w_key;
                            n_pos     = w_key;
                            n_state   = S_LOAD;
                        end
                    end else begin
                        if (r_held == '0) begin
                            w_fin        = 1'b1;
                            w_res.status = STAT_EMPTY;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = r_scan;
                            n_pos     = r_scan;
                            n_state   = S_SCAN;
                        end
                    end
                end
            end
            S_LOAD: begin
                // bin count is back: increment and write
                o_wr_en   = 1'b1;
                o_wr_data = i_rd_data + 1'b1;
                n_held    = r_held + 1'b1;
                if (r_pos < r_scan) begin
                    n_scan = r_pos;
                end
                w_fin = 1'b1;
            end
            S_SCAN: begin
                if (i_rd_data != '0) begin
                    // first occupied bin: take one key out
                    o_wr_en   = 1'b1;
                    o_wr_data = i_rd_data - 1'b1;
                    n_held    = r_held - 1'b1;
                    n_scan    = r_pos;
                    w_fin     = 1'b1;
                    w_res.key  = w_pos_ext[KEY_W-1:0];
                    w_res.last = (r_held == CNT_W'(1));
                end else begin
                    // empty bin: read the next one, one bin a cycle
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_pos + 1'b1;
                    n_pos     = r_pos + 1'b1;
                end
            end
            S_HOLD: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // Finished result goes out at once or waits in the hold register
        if (w_fin) begin
            n_state = i_slot_free ? S_IDLE : S_HOLD;
        end
    end

    assign n_res       = w_fin ? w_res : r_res;
    assign o_res       = (r_state == S_HOLD) ? r_res : w_res;
    assign o_res_valid = (w_fin || (r_state == S_HOLD)) && i_slot_free;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_held  <= '0;
            r_scan  <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_scan  <= n_scan;
            r_clr   <= n_clr;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_res <= n_res;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cse_out.sv =====
// Output register stage for the result stream
`timescale 1ns / 1ps
`default_nettype none

module cse_out (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_res_valid,
    input  wire cse_pkg::t_result  i_res,
    output logic                   o_slot_free,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output cse_pkg::t_result       o_res
);

    import cse_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Slot is free when empty or being taken this cycle
    assign o_slot_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ===== hw/rtl/cse_checker.sv =====
// Port-level checker for the counting sort engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "counting_sort_engine_top_assert.svh"

module cse_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    input  wire logic                        i_s_tready,
    input  wire logic                        i_m_tvalid,
    input  wire logic                        i_m_tready,
    input  wire logic [cse_pkg::DATA_W-1:0]  i_m_tdata,
    input  wire logic                        i_m_tlast,
    input  wire logic [1:0]                  i_m_tuser
);

    import cse_pkg::*;

    logic       w_in_acc, w_out_acc;
    logic [1:0] r_pend;

    assign w_in_acc  = i_s_tvalid && i_s_tready;
    assign w_out_acc = i_m_tvalid && i_m_tready;

    // Requests taken whose results are not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, w_in_acc} - {1'b0, w_out_acc};
        end
    end

    `CSE_ASSERT_NEXT(a_hold_stall, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast) && $stable(i_m_tuser))
    `CSE_ASSERT_NOW(a_no_invented, i_m_tvalid, r_pend != 2'd0)
    `CSE_ASSERT_NOW(a_pend_bound, 1'b1, r_pend <= 2'd2)
    `CSE_ASSERT_NOW(a_last_ok, i_m_tvalid && i_m_tlast, i_m_tuser == STAT_OK)
    `CSE_ASSERT_NOW(a_fail_zero, i_m_tvalid && (i_m_tuser != STAT_OK), (i_m_tdata == '0) && !i_m_tlast)

endmodule

bind counting_sort_engine_top cse_checker u_cse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast),
    .i_m_tuser  (o_m_axis_tuser)
);

`default_nettype wire
